// ----- rtl/wavp_pkg.sv -----
`default_nettype none

package wavp_pkg;

   // Result status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_RIFF    = 3'd1;
   localparam logic [2:0] ST_NO_HDR      = 3'd2;
   localparam logic [2:0] ST_FMT_SHORT   = 3'd3;
   localparam logic [2:0] ST_BAD_FORMAT  = 3'd4;
   localparam logic [2:0] ST_BAD_BITS    = 3'd5;
   localparam logic [2:0] ST_TRUNC_CHUNK = 3'd6;
   localparam logic [2:0] ST_DATA_FIRST  = 3'd7;

   // Result kinds
   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // Four-character codes as they appear in the byte stream, first byte on top
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   // Input request
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // Result
   typedef struct packed {
      logic        result_kind;
      logic [2:0]  status;
      logic [1:0]  num_channels;
      logic [31:0] sample_rate;
      logic [4:0]  sample_bits;
      logic [31:0] data_offset;
      logic [31:0] frame_count;
      logic [7:0]  payload_byte;
      logic        payload_last;
   } rsp_type;

   // Event from the parser to the output side; chunk length is not yet scaled
   typedef struct packed {
      logic        kind;
      logic [2:0]  status;
      logic [1:0]  channels;
      logic [31:0] rate;
      logic [4:0]  bits;
      logic [31:0] offset;
      logic [31:0] length;
      logic [7:0]  pay_byte;
      logic        pay_last;
   } evt_type;

endpackage

`default_nettype wire

// ----- rtl/wavp_front.sv -----
`default_nettype none

module wavp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire wavp_pkg::req_type req_item,
   input  wire logic              queue_full,
   output logic                   evt_push,
   output wavp_pkg::evt_type      evt
);
   import wavp_pkg::*;

   typedef enum logic [2:0] {
      PH_RIFF, PH_HDR, PH_FMT, PH_FMTSKIP, PH_SKIP, PH_PASS, PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [63:0] shift_ff, shift_in;
   logic [31:0] skip_ff, skip_in;
   logic [1:0]  ch_ff, ch_in;
   logic [31:0] rate_ff, rate_in;
   logic [4:0]  bits_ff, bits_in;
   logic        seen_ff, seen_in;
   logic [3:0]  hcnt_ff, hcnt_in;

   logic        accept;
   logic        last;
   logic [63:0] shifted;
   logic [31:0] w;
   logic [31:0] id;
   logic [31:0] len;
   logic [15:0] tag16;
   logic [15:0] ch16;
   logic [15:0] bits16;
   logic [4:0]  bits_new;
   logic [3:0]  hcnt_inc;
   logic        fail;
   logic [2:0]  fail_code;
   logic        finish;
   logic [4:0]  finish_bits;
   logic        to_hdr;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign last      = req_item.last_byte;
   assign shifted   = {shift_ff[55:0], req_item.data_byte};
   assign w         = shifted[31:0];
   assign id        = shifted[63:32];
   assign len       = {w[7:0], w[15:8], w[23:16], w[31:24]};
   assign tag16     = {w[23:16], w[31:24]};
   assign ch16      = {w[7:0], w[15:8]};
   assign bits16    = {w[7:0], w[15:8]};
   assign bits_new  = (bits16 == 16'd8 || bits16 == 16'd16) ? bits16[4:0] : 5'd0;
   assign hcnt_inc  = hcnt_ff + 4'd1;

   // Parse one byte
   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      shift_in    = shift_ff;
      skip_in     = skip_ff;
      ch_in       = ch_ff;
      rate_in     = rate_ff;
      bits_in     = bits_ff;
      seen_in     = seen_ff;
      hcnt_in     = hcnt_ff;
      evt_push    = 1'b0;
      evt         = '0;
      fail        = 1'b0;
      fail_code   = ST_OK;
      finish      = 1'b0;
      finish_bits = bits_ff;
      to_hdr      = 1'b0;
      if (accept && phase_ff != PH_DONE) begin
         pos_in   = pos_ff + 32'd1;
         shift_in = shifted;
         unique case (phase_ff)
            PH_RIFF: begin
               priority if (pos_ff == 32'd3 && w != TAG_RIFF) begin
                  fail = 1'b1; fail_code = ST_BAD_RIFF;
               end else if (pos_ff == 32'd7 && (len == 32'd0 || len[31])) begin
                  fail = 1'b1; fail_code = ST_BAD_RIFF;
               end else if (pos_ff == 32'd11) begin
                  if (w != TAG_WAVE) begin
                     fail = 1'b1; fail_code = ST_BAD_RIFF;
                  end else begin
                     to_hdr = 1'b1;
                  end
               end else if (last) begin
                  fail = 1'b1; fail_code = ST_BAD_RIFF;
               end
            end
            PH_HDR: begin
               hcnt_in = hcnt_inc;
               priority if (hcnt_inc < 4'd8) begin
                  if (last) begin
                     fail = 1'b1; fail_code = ST_NO_HDR;
                  end
               end else if (id == TAG_DATA) begin
                  if (!seen_ff) begin
                     fail = 1'b1; fail_code = ST_DATA_FIRST;
                  end else begin
                     evt_push     = 1'b1;
                     evt.kind     = KIND_HEADER;
                     evt.status   = ST_OK;
                     evt.channels = ch_ff;
                     evt.rate     = rate_ff;
                     evt.bits     = bits_ff;
                     evt.offset   = pos_ff + 32'd1;
                     evt.length   = len;
                     phase_in     = last ? PH_DONE : PH_PASS;
                  end
               end else if (id == TAG_FMT && !seen_ff && len[31:4] != 28'd0) begin
                  if (last) begin
                     fail = 1'b1; fail_code = ST_FMT_SHORT;
                  end else begin
                     skip_in  = len - 32'd16;
                     hcnt_in  = 4'd0;
                     phase_in = PH_FMT;
                  end
               end else begin
                  skip_in = len;
                  priority if (len == 32'd0) begin
                     to_hdr = 1'b1;
                  end else if (last) begin
                     fail = 1'b1; fail_code = ST_TRUNC_CHUNK;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_FMT: begin
               hcnt_in = hcnt_inc;
               priority if (hcnt_ff == 4'd15) begin
                  bits_in = bits_new;
                  priority if (ch_ff == 2'd0) begin
                     fail = 1'b1; fail_code = ST_BAD_FORMAT;
                  end else if (skip_ff == 32'd0) begin
                     finish = 1'b1; finish_bits = bits_new;
                  end else if (last) begin
                     fail = 1'b1; fail_code = ST_TRUNC_CHUNK;
                  end else begin
                     phase_in = PH_FMTSKIP;
                  end
               end else begin
                  if (hcnt_ff == 4'd3) begin
                     ch_in = (tag16 == 16'd1 && (ch16 == 16'd1 || ch16 == 16'd2)) ?
                             ch16[1:0] : 2'd0;
                  end
                  if (hcnt_ff == 4'd7) begin
                     rate_in = len;
                  end
                  if (last) begin
                     fail = 1'b1; fail_code = ST_FMT_SHORT;
                  end
               end
            end
            PH_FMTSKIP: begin
               skip_in = skip_ff - 32'd1;
               priority if (skip_ff == 32'd1) begin
                  finish = 1'b1;
               end else if (last) begin
                  fail = 1'b1; fail_code = ST_TRUNC_CHUNK;
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 32'd1;
               priority if (skip_ff == 32'd1) begin
                  to_hdr = 1'b1;
               end else if (last) begin
                  fail = 1'b1; fail_code = ST_TRUNC_CHUNK;
               end
            end
            PH_PASS: begin
               evt_push     = 1'b1;
               evt.kind     = KIND_PAYLOAD;
               evt.pay_byte = req_item.data_byte;
               evt.pay_last = last;
               if (last) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase

         // Close the fmt chunk: the bit depth decides
         if (finish) begin
            if (finish_bits == 5'd0) begin
               fail = 1'b1; fail_code = ST_BAD_BITS;
            end else begin
               seen_in = 1'b1;
               to_hdr  = 1'b1;
            end
         end

         // Expect a chunk header next
         if (to_hdr && !fail) begin
            if (last) begin
               fail = 1'b1; fail_code = ST_NO_HDR;
            end else begin
               phase_in = PH_HDR;
               hcnt_in  = 4'd0;
            end
         end

         // Report the error and drop everything after it
         if (fail) begin
            phase_in   = PH_DONE;
            evt_push   = 1'b1;
            evt        = '0;
            evt.status = fail_code;
         end
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         pos_ff   <= '0;
         shift_ff <= '0;
         skip_ff  <= '0;
         ch_ff    <= '0;
         rate_ff  <= '0;
         bits_ff  <= '0;
         seen_ff  <= 1'b0;
         hcnt_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
         skip_ff  <= skip_in;
         ch_ff    <= ch_in;
         rate_ff  <= rate_in;
         bits_ff  <= bits_in;
         seen_ff  <= seen_in;
         hcnt_ff  <= hcnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wavp_queue.sv -----
`default_nettype none

module wavp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire wavp_pkg::evt_type push_evt,
   output logic                   full,
   output logic                   not_empty,
   input  wire logic              pop,
   output wavp_pkg::evt_type      head_evt
);
   import wavp_pkg::*;

   evt_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_evt  = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_evt;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wavp_back.sv -----
`default_nettype none

module wavp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              evt_valid,
   input  wire wavp_pkg::evt_type evt,
   output logic                   evt_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wavp_pkg::rsp_type      rsp_item
);
   import wavp_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;
   logic    load;
   logic [1:0] frame_shift;

   assign load        = evt_valid && (!rsp_valid_ff || !rsp_stall);
   assign evt_pop     = load;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_item_ff;
   assign frame_shift = {1'b0, evt.channels == 2'd2} + {1'b0, evt.bits == 5'd16};

   // Format the event into a result
   always_comb begin
      rsp_item_in = '0;
      priority if (evt.kind == KIND_PAYLOAD) begin
         rsp_item_in.result_kind  = KIND_PAYLOAD;
         rsp_item_in.payload_byte = evt.pay_byte;
         rsp_item_in.payload_last = evt.pay_last;
      end else if (evt.status != ST_OK) begin
         rsp_item_in.status = evt.status;
      end else begin
         rsp_item_in.num_channels = evt.channels;
         rsp_item_in.sample_rate  = evt.rate;
         rsp_item_in.sample_bits  = evt.bits;
         rsp_item_in.data_offset  = evt.offset;
         rsp_item_in.frame_count  = evt.length >> frame_shift;
      end
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Hold the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/wav_header_parser.sv -----
`default_nettype none

// Channel   Ports                          Direction  Moves
// --------  -----------------------------  ---------  -------------------------------
// request   req_valid, req_stall, req_item  in         one file byte and last flag
// result    rsp_valid, rsp_stall, rsp_item  out        header, error or payload byte
//
// One byte is taken per clock while req_stall is low; the parser decides each byte
// in the cycle it is taken. Results pass a two-entry queue and then an output register.
// req_stall rises only while the queue is full, i.e. while rsp_stall holds results back.
// Reset is synchronous and active high; it returns the parser to the RIFF header.
module wav_header_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire wavp_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wavp_pkg::rsp_type      rsp_item
);
   import wavp_pkg::*;

   logic    queue_full;
   logic    evt_push;
   evt_type evt;
   logic    head_valid;
   logic    head_pop;
   evt_type head_evt;

   wavp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .queue_full (queue_full),
      .evt_push   (evt_push),
      .evt        (evt)
   );

   wavp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_evt  (evt),
      .full      (queue_full),
      .not_empty (head_valid),
      .pop       (head_pop),
      .head_evt  (head_evt)
   );

   wavp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (head_valid),
      .evt       (head_evt),
      .evt_pop   (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire
